### hw/rtl/cubic_bisection_root_macros.svh
// Assertion helpers shared by the cubic bisection root finder RTL.
// Every property samples on the rising edge of clk and is off while rst_n is low.
`ifndef CUBIC_BISECTION_ROOT_MACROS_SVH
`define CUBIC_BISECTION_ROOT_MACROS_SVH

// Same-cycle implication.
`define CBR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CBR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbr_pkg.sv
package cbr_pkg;

    // Fixed widths of the ports and the configuration registers
    localparam int IO_BITS       = 32;
    localparam int TOL_BITS      = 31;
    localparam int STEP_BITS     = 7;
    localparam int CFG_DATA_BITS = 31;
    localparam int CFG_IDX_BITS  = 1;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_LIMIT = 1'b1;

    // Reset values
    localparam logic [TOL_BITS-1:0]  TOL_RESET  = 31'd66;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 7'd32;

    // Horner term index of the constant term (last multiply-add of an evaluation)
    localparam logic [1:0] LAST_TERM = 2'd2;

    // Query sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EVAL_LO,
        ST_EVAL_HI,
        ST_EVAL_MID,
        ST_DONE
    } cbr_state_t;

    // Shared multiply-add unit
    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MUL,
        HS_ADD
    } cbr_hstate_t;

endpackage

### hw/rtl/cbr_horner.sv
module cbr_horner #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] x,
    input  logic signed [WORD_BITS-1:0] c3,
    input  logic signed [WORD_BITS-1:0] c2,
    input  logic signed [WORD_BITS-1:0] c1,
    input  logic signed [WORD_BITS-1:0] c0,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] p
);
    import cbr_pkg::*;

    // Multiplier operand slice: whole word up to 32 bits, two halves above
    localparam int DIG  = (WORD_BITS > 32) ? (WORD_BITS + 1) / 2 : WORD_BITS;
    localparam int NDIG = (WORD_BITS + DIG - 1) / DIG;
    localparam int BW   = NDIG * DIG;
    localparam int PW   = WORD_BITS + BW + 1;
    localparam int DPW  = WORD_BITS + DIG + 1;
    localparam int DCW  = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam logic signed [PW-1:0] Q_MAX =
        {{(PW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [PW-1:0] Q_MIN = ~Q_MAX;
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    cbr_hstate_t state_reg, state_next;
    logic [1:0]                  term_reg, term_next;
    logic [DCW-1:0]              dig_reg, dig_next;
    logic                        done_reg, done_next;
    logic signed [WORD_BITS-1:0] p_reg, p_next;
    logic signed [PW-1:0]        acc_reg, acc_next;

    logic signed [BW-1:0]        x_ext;
    logic [DIG-1:0]              chunk;
    logic                        last_dig;
    logic signed [DIG:0]         digit;
    logic signed [DPW-1:0]       part;
    logic signed [PW-1:0]        part_sh;
    logic signed [PW-1:0]        q;
    logic signed [WORD_BITS-1:0] q_sat;
    logic signed [WORD_BITS-1:0] addend;
    logic signed [WORD_BITS:0]   sum;
    logic signed [WORD_BITS-1:0] sum_sat;

    // Partial product: running value times one slice of the operand
    assign x_ext    = BW'(x);
    assign chunk    = x_ext[dig_reg * DIG +: DIG];
    assign last_dig = (dig_reg == DCW'(NDIG - 1));
    assign digit    = last_dig ? {chunk[DIG-1], chunk} : {1'b0, chunk};
    assign part     = p_reg * digit;
    assign part_sh  = PW'(part) <<< (dig_reg * DIG);

    // Floor shift, saturate, add the next coefficient, saturate again
    assign q     = acc_reg >>> FRAC_BITS;
    assign q_sat = (q > Q_MAX) ? W_MAX : ((q < Q_MIN) ? W_MIN : q[WORD_BITS-1:0]);

    always_comb
    begin
        case (term_reg)
            2'd0:    addend = c2;
            2'd1:    addend = c1;
            default: addend = c0;
        endcase
    end

    assign sum     = {q_sat[WORD_BITS-1], q_sat} + {addend[WORD_BITS-1], addend};
    assign sum_sat = (sum[WORD_BITS] != sum[WORD_BITS-1])
                   ? (sum[WORD_BITS] ? W_MIN : W_MAX) : sum[WORD_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        dig_next   = dig_reg;
        done_next  = 1'b0;
        p_next     = p_reg;
        acc_next   = acc_reg;
        case (state_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    p_next     = c3;
                    term_next  = 2'd0;
                    dig_next   = '0;
                    state_next = HS_MUL;
                end
            end
            HS_MUL:
            begin
                acc_next = ((dig_reg == '0) ? '0 : acc_reg) + part_sh;
                if (last_dig)
                begin
                    dig_next   = '0;
                    state_next = HS_ADD;
                end
                else
                begin
                    dig_next = dig_reg + DCW'(1);
                end
            end
            HS_ADD:
            begin
                p_next = sum_sat;
                if (term_reg == LAST_TERM)
                begin
                    done_next  = 1'b1;
                    state_next = HS_IDLE;
                end
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = HS_MUL;
                end
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            term_reg  <= 2'd0;
            dig_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            dig_reg   <= dig_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

### hw/rtl/cubic_bisection_root.sv
// Cubic bisection root finder. Each input transaction carries the four
// coefficients of p(t) = c3*t^3 + c2*t^2 + c1*t + c0 and a search interval, all
// signed fixed point (Q16.16 at the default WORD_BITS/FRAC_BITS); each produces
// exactly one output transaction with found and root. The cubic is evaluated at
// both ends first; if the ends fall in the same sign class (both <= 0 or both > 0)
// or step_limit is zero, the answer is not found. Otherwise up to step_limit
// midpoints are evaluated and the first one with |p| <= tolerance is returned;
// root reads zero when found is low. Every evaluation runs on one shared
// multiply-add unit: three dependent Horner steps, each M multiplier passes plus
// one saturating add, where M is 1 for WORD_BITS up to 32 and 2 above. The block
// takes one query at a time: in_ready is high only while it is idle, and a new
// query may be accepted while the previous result still waits in the output
// register. Write tolerance and step_limit only while no query is in flight.
`include "cubic_bisection_root_macros.svh"

module cubic_bisection_root #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Query channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_cubic,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_square,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_linear,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_const,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   interval_start,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   interval_end,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic signed [cbr_pkg::IO_BITS-1:0]   root,
    // Configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [cbr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [cbr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import cbr_pkg::*;

    // Widths for input saturation, tolerance compare and root output
    localparam int EW = ((WORD_BITS > IO_BITS) ? WORD_BITS : IO_BITS) + 1;
    localparam int CW = ((WORD_BITS > TOL_BITS) ? WORD_BITS : TOL_BITS) + 2;
    localparam int RW = (WORD_BITS > IO_BITS) ? WORD_BITS : IO_BITS;

    localparam logic signed [EW-1:0] IN_MAX =
        {{(EW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [EW-1:0] IN_MIN = ~IN_MAX;
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    // Clamp a port value into the internal word range
    function automatic logic signed [WORD_BITS-1:0] sat_in(input logic signed [IO_BITS-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > IN_MAX)
        begin
            return W_MAX;
        end
        if (e < IN_MIN)
        begin
            return W_MIN;
        end
        return e[WORD_BITS-1:0];
    endfunction

    // floor((a + b) / 2), exact
    function automatic logic signed [WORD_BITS-1:0] midpoint(
        input logic signed [WORD_BITS-1:0] a,
        input logic signed [WORD_BITS-1:0] b
    );
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        return s[WORD_BITS:1];
    endfunction

    cbr_state_t state_reg, state_next;

    // Configuration
    logic [TOL_BITS-1:0]  tol_reg;
    logic [STEP_BITS-1:0] step_limit_reg;

    // Query payload and search state
    logic signed [WORD_BITS-1:0] c3_reg, c3_next;
    logic signed [WORD_BITS-1:0] c2_reg, c2_next;
    logic signed [WORD_BITS-1:0] c1_reg, c1_next;
    logic signed [WORD_BITS-1:0] c0_reg, c0_next;
    logic signed [WORD_BITS-1:0] t0_reg, t0_next;
    logic signed [WORD_BITS-1:0] t1_reg, t1_next;
    logic signed [WORD_BITS-1:0] x_reg, x_next;
    logic                        s0_reg, s0_next;
    logic [STEP_BITS-1:0]        iter_reg, iter_next;
    logic                        res_found_reg, res_found_next;
    logic signed [WORD_BITS-1:0] res_root_reg, res_root_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic signed [IO_BITS-1:0]   root_reg, root_next;
    logic                        out_load;

    // Shared evaluation unit
    logic                        h_start;
    logic                        h_done;
    logic signed [WORD_BITS-1:0] h_p;

    logic                        p_nonpos;
    logic signed [CW-1:0]        p_c;
    logic signed [CW-1:0]        tol_c;
    logic                        hit;
    logic signed [RW-1:0]        res_root_ext;

    cbr_horner #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_horner (
        .clk   (clk),
        .rst_n (rst_n),
        .start (h_start),
        .x     (x_reg),
        .c3    (c3_reg),
        .c2    (c2_reg),
        .c1    (c1_reg),
        .c0    (c0_reg),
        .done  (h_done),
        .p     (h_p)
    );

    // Sign class and tolerance window of the value just evaluated
    assign p_nonpos = h_p[WORD_BITS-1] || (h_p == '0);
    assign p_c      = CW'(h_p);
    assign tol_c    = CW'(tol_reg);
    assign hit      = (p_c <= tol_c) && (p_c >= -tol_c);

    assign res_root_ext = RW'(res_root_reg);

    always_comb
    begin
        state_next     = state_reg;
        c3_next        = c3_reg;
        c2_next        = c2_reg;
        c1_next        = c1_reg;
        c0_next        = c0_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        x_next         = x_reg;
        s0_next        = s0_reg;
        iter_next      = iter_reg;
        res_found_next = res_found_reg;
        res_root_next  = res_root_reg;
        h_start        = 1'b0;
        out_load       = 1'b0;
        in_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the query; unless step_limit is zero, ST_LOAD then starts the unit on the stored values
                if (in_valid)
                begin
                    c3_next = sat_in(coef_cubic);
                    c2_next = sat_in(coef_square);
                    c1_next = sat_in(coef_linear);
                    c0_next = sat_in(coef_const);
                    t0_next = sat_in(interval_start);
                    t1_next = sat_in(interval_end);
                    x_next  = sat_in(interval_start);
                    if (step_limit_reg == '0)
                    begin
                        res_found_next = 1'b0;
                        res_root_next  = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                h_start    = 1'b1;
                state_next = ST_EVAL_LO;
            end
            ST_EVAL_LO:
            begin
                // Record the lower end's sign class, move on to the upper end
                if (h_done)
                begin
                    s0_next    = p_nonpos;
                    x_next     = t1_reg;
                    h_start    = 1'b1;
                    state_next = ST_EVAL_HI;
                end
            end
            ST_EVAL_HI:
            begin
                if (h_done)
                begin
                    if (p_nonpos == s0_reg)
                    begin
                        // No sign change across the interval: answer not found
                        res_found_next = 1'b0;
                        res_root_next  = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        x_next     = midpoint(t0_reg, t1_reg);
                        iter_next  = '0;
                        h_start    = 1'b1;
                        state_next = ST_EVAL_MID;
                    end
                end
            end
            ST_EVAL_MID:
            begin
                if (h_done)
                begin
                    if (hit)
                    begin
                        res_found_next = 1'b1;
                        res_root_next  = x_reg;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        // Keep the half whose end differs in sign class from the midpoint
                        if (p_nonpos == s0_reg)
                        begin
                            t0_next = x_reg;
                        end
                        else
                        begin
                            t1_next = x_reg;
                        end
                        if ((iter_reg + STEP_BITS'(1)) == step_limit_reg)
                        begin
                            res_found_next = 1'b0;
                            res_root_next  = '0;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            x_next     = midpoint(t0_next, t1_next);
                            iter_next  = iter_reg + STEP_BITS'(1);
                            h_start    = 1'b1;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once the transaction completes
    always_comb
    begin
        found_next = found_reg;
        root_next  = root_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            found_next     = res_found_reg;
            root_next      = res_root_ext[IO_BITS-1:0];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            tol_reg        <= TOL_RESET;
            step_limit_reg <= STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_TOLERANCE:  tol_reg        <= cfg_data[TOL_BITS-1:0];
                    CFG_STEP_LIMIT: step_limit_reg <= cfg_data[STEP_BITS-1:0];
                    default:        tol_reg        <= tol_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c3_reg        <= c3_next;
        c2_reg        <= c2_next;
        c1_reg        <= c1_next;
        c0_reg        <= c0_next;
        t0_reg        <= t0_next;
        t1_reg        <= t1_next;
        x_reg         <= x_next;
        s0_reg        <= s0_next;
        iter_reg      <= iter_next;
        res_found_reg <= res_found_next;
        res_root_reg  <= res_root_next;
        found_reg     <= found_next;
        root_reg      <= root_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign root      = root_reg;

    `CBR_ASSERT_IMP(a_nf_root_zero, out_valid_reg && !found_reg, root_reg == '0,
        "root must be zero when not found")
    `CBR_ASSERT_IMP(a_done_in_eval, h_done,
        state_reg == ST_EVAL_LO || state_reg == ST_EVAL_HI || state_reg == ST_EVAL_MID,
        "evaluation finished outside an evaluation state")
    `CBR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "query accepted but block still ready")

endmodule

### dv/bisection_check.sv
`timescale 1ns / 100ps

module bisection_check (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_cubic,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_square,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_linear,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   coef_const,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   interval_start,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   interval_end,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 found,
    input  logic signed [cbr_pkg::IO_BITS-1:0]   root,
    input  logic                                 cfg_wr_en,
    input  logic [cbr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [cbr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output int                                   mismatches,
    output int                                   outstanding
);
    import cbr_pkg::*;

    localparam int     WORD_BITS = 32;
    localparam int     FRAC_BITS = 16;
    localparam longint WORD_MAX  = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint WORD_MIN  = -WORD_MAX - 1;

    typedef struct packed {
        logic                      hit;
        logic signed [IO_BITS-1:0] at;
    } root_answer_t;

    root_answer_t           answers_due[$];
    logic [TOL_BITS-1:0]    tol_reg;
    logic [STEP_BITS-1:0]   steps_reg;

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // Floor of the Q product; operands never exceed 32 bits, so 64 bits hold it exactly.
    function automatic longint fixed_mul(input longint a, input longint b);
        return clamp_word((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint cubic_at(input longint c3, input longint c2,
                                        input longint c1, input longint c0,
                                        input longint t);
        longint p;
        p = c3;
        p = clamp_word(fixed_mul(p, t) + c2);
        p = clamp_word(fixed_mul(p, t) + c1);
        p = clamp_word(fixed_mul(p, t) + c0);
        return p;
    endfunction

    function automatic root_answer_t bisect(input longint c3, input longint c2,
                                            input longint c1, input longint c0,
                                            input longint lo, input longint hi);
        root_answer_t ans;
        longint       tol;
        longint       mid;
        longint       p;
        logic         lo_np;
        logic         hi_np;
        ans = '0;
        tol = longint'(tol_reg);
        if (steps_reg != '0)
        begin
            lo_np = cubic_at(c3, c2, c1, c0, lo) <= 0;
            hi_np = cubic_at(c3, c2, c1, c0, hi) <= 0;
            if (lo_np != hi_np)
            begin
                for (int i = 0; i < int'(steps_reg); i++)
                begin
                    mid = (lo + hi) >>> 1;
                    p   = cubic_at(c3, c2, c1, c0, mid);
                    if (p <= tol && p >= -tol)
                    begin
                        ans.hit = 1'b1;
                        ans.at  = mid[IO_BITS-1:0];
                        break;
                    end
                    if ((p <= 0) == lo_np)
                        lo = mid;
                    else
                        hi = mid;
                end
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        root_answer_t want;
        if (!rst_n)
        begin
            tol_reg    = TOL_RESET;
            steps_reg  = STEP_RESET;
            mismatches = 0;
            answers_due.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                answers_due.push_back(bisect(longint'(coef_cubic), longint'(coef_square),
                                             longint'(coef_linear), longint'(coef_const),
                                             longint'(interval_start),
                                             longint'(interval_end)));
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with none pending: found %0b root %0d",
                                 $realtime, found, root);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (found !== want.hit || root !== want.at)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: found %0b root %0d, expected %0b root %0d",
                                     $realtime, found, root, want.hit, want.at);
                        mismatches++;
                    end
                end
            end
            // Register writes take effect after this edge.
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_TOLERANCE)
                    tol_reg = cfg_data[TOL_BITS-1:0];
                else if (cfg_index == CFG_STEP_LIMIT)
                    steps_reg = cfg_data[STEP_BITS-1:0];
            end
        end
        outstanding = answers_due.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import cbr_pkg::*;

    // Q16.16 landmarks for the directed queries
    localparam logic signed [IO_BITS-1:0] ONE  = 32'sd65536;
    localparam logic signed [IO_BITS-1:0] WMAX = 32'sh7FFFFFFF;
    localparam logic signed [IO_BITS-1:0] WMIN = 32'sh80000000;

    // Cycle budget for the whole run, sized for queries at step_limit 127 with
    // random gaps on both channels.
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 72;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [IO_BITS-1:0]   coef_cubic;
    logic signed [IO_BITS-1:0]   coef_square;
    logic signed [IO_BITS-1:0]   coef_linear;
    logic signed [IO_BITS-1:0]   coef_const;
    logic signed [IO_BITS-1:0]   interval_start;
    logic signed [IO_BITS-1:0]   interval_end;
    logic                        out_valid;
    logic                        out_ready;
    logic                        found;
    logic signed [IO_BITS-1:0]   root;
    logic                        cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    int                          mismatches;
    int                          outstanding;
    int                          cycle_count = 0;
    // Set for whole phases to run both channels back to back.
    bit                          no_gaps = 1'b0;

    cubic_bisection_root uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .coef_cubic     (coef_cubic),
        .coef_square    (coef_square),
        .coef_linear    (coef_linear),
        .coef_const     (coef_const),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .root           (root),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    bisection_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .coef_cubic     (coef_cubic),
        .coef_square    (coef_square),
        .coef_linear    (coef_linear),
        .coef_const     (coef_const),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .root           (root),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Random value of up to the given number of magnitude bits, either sign.
    function automatic logic signed [IO_BITS-1:0] signed_mag(input int bits);
        logic signed [IO_BITS-1:0] mag;
        mag = $urandom_range(0, (32'd1 << bits) - 1);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic signed [IO_BITS-1:0] corner_value();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 32'sd1;
            2:       return -32'sd1;
            3:       return ONE;
            4:       return -ONE;
            5:       return WMAX;
            default: return WMIN;
        endcase
    endfunction

    // Present one query and hold it until the block takes it. Entered and left
    // on a falling edge; valid stays high on return so a back-to-back query
    // never drops it for a single step.
    task automatic send_query(input logic signed [IO_BITS-1:0] c3, c2, c1, c0, lo, hi);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        coef_cubic     <= c3;
        coef_square    <= c2;
        coef_linear    <= c1;
        coef_const     <= c0;
        interval_start <= lo;
        interval_end   <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain the block, then write one register. The index port is one bit wide,
    // so every index it can carry names a real register.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Step limit with junk in the upper data bits; the block must drop them.
    task automatic write_steps(input logic [STEP_BITS-1:0] steps);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = CFG_DATA_BITS'($urandom());
        write_reg(CFG_STEP_LIMIT, {junk[CFG_DATA_BITS-1:STEP_BITS], steps});
    endtask

    // Mostly cubics built around a known root with a bracket that usually
    // straddles it, so the search runs deep; the rest is small random, full
    // random noise and corner values.
    task automatic random_query();
        int                        kind;
        int                        w;
        logic signed [IO_BITS-1:0] c3, c2, c1, c0, lo, hi, r, tmp;
        real                       x;
        real                       acc;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            c3 = signed_mag($urandom_range(0, 18));
            c2 = signed_mag($urandom_range(0, 19));
            c1 = signed_mag($urandom_range(0, 20));
            r  = signed_mag($urandom_range(4, 19));
            x  = real'(r) / 65536.0;
            // Choose the constant so that p(r) is close to zero.
            acc = -(((real'(c3) * x + real'(c2)) * x + real'(c1)) * x);
            if (acc > 2147483647.0)
                acc = 2147483647.0;
            if (acc < -2147483648.0)
                acc = -2147483648.0;
            c0 = $rtoi(acc);
            w  = $urandom_range(2, 20);
            lo = r - $urandom_range(1, 32'd1 << w);
            hi = r + $urandom_range(1, 32'd1 << w);
            if ($urandom_range(0, 3) == 0)
            begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
        end
        else if (kind <= 7)
        begin
            c3 = signed_mag($urandom_range(0, 24));
            c2 = signed_mag($urandom_range(0, 24));
            c1 = signed_mag($urandom_range(0, 24));
            c0 = signed_mag($urandom_range(0, 24));
            lo = signed_mag($urandom_range(0, 24));
            hi = signed_mag($urandom_range(0, 24));
        end
        else if (kind == 8)
        begin
            c3 = $urandom();
            c2 = $urandom();
            c1 = $urandom();
            c0 = $urandom();
            lo = $urandom();
            hi = $urandom();
        end
        else
        begin
            c3 = corner_value();
            c2 = corner_value();
            c1 = corner_value();
            c0 = corner_value();
            lo = corner_value();
            hi = corner_value();
        end
        send_query(c3, c2, c1, c0, lo, hi);
    endtask

    // Result side: unless no_gaps is set, stall a random number of cycles before each
    // transaction, then hold ready high until it is taken.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        coef_cubic     = '0;
        coef_square    = '0;
        coef_linear    = '0;
        coef_const     = '0;
        interval_start = '0;
        interval_end   = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_TOLERANCE;
        cfg_data       = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed queries at the reset settings.
        // Root exactly at the first midpoint.
        send_query('0, '0, ONE, '0, -ONE, ONE);
        // Root sits on an end: only midpoints may be accepted, so it creeps in.
        send_query('0, '0, ONE, '0, '0, ONE);
        // Reversed interval.
        send_query('0, '0, ONE, -(ONE >>> 1), ONE, '0);
        // Irrational root, sqrt(2).
        send_query(ONE, '0, -2 * ONE, '0, ONE, 2 * ONE);
        // Both ends positive.
        send_query('0, ONE, '0, ONE, -ONE, ONE);
        // Both ends non-positive (identically zero).
        send_query('0, '0, '0, '0, -ONE, ONE);
        // Equal ends.
        send_query(ONE, '0, -ONE, '0, ONE >>> 1, ONE >>> 1);
        // All fields at their extremes.
        send_query(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        send_query(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        send_query(WMIN, WMAX, WMIN, WMAX, WMAX, WMIN);
        // Saturating Horner products across the full range.
        send_query(ONE, '0, '0, '0, WMIN, WMAX);
        send_query('0, '0, WMAX, WMIN, -ONE, ONE);
        // Tiny ends around zero exercise floor rounding of the midpoint.
        send_query('0, '0, -ONE, 32'sd3, -32'sd5, 32'sd7);
        // Root at one third never lands exactly.
        send_query('0, '0, 3 * ONE, -ONE, '0, ONE);
        send_query('0, ONE, '0, -4 * ONE, '0, 8 * ONE);
        // Alternating bit patterns.
        send_query(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                   32'shAAAAAAAA, 32'sh55555555);

        // Random phases, each under its own settings, extremes among them.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_TOLERANCE, CFG_DATA_BITS'($urandom_range(0, 4095)));
                    write_steps(7'd32);
                end
                1:
                begin
                    write_reg(CFG_TOLERANCE, '0);
                    write_steps(7'd64);
                end
                2:
                begin
                    write_reg(CFG_TOLERANCE, {TOL_BITS{1'b1}});
                    write_steps(7'd10);
                end
                3:
                begin
                    write_reg(CFG_TOLERANCE, CFG_DATA_BITS'($urandom_range(0, 15)));
                    write_steps(7'd127);
                end
                4:
                begin
                    write_reg(CFG_TOLERANCE, TOL_RESET);
                    write_steps(7'd0);
                end
                5:
                begin
                    write_reg(CFG_TOLERANCE, 31'd1000);
                    write_steps(7'd1);
                end
                6:
                begin
                    write_reg(CFG_TOLERANCE, CFG_DATA_BITS'($urandom() >> 1));
                    write_steps(STEP_BITS'($urandom_range(1, 64)));
                end
                default:
                begin
                    write_reg(CFG_TOLERANCE, CFG_DATA_BITS'($urandom_range(0, 255)));
                    write_steps(7'd40);
                end
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) random_query();
        end

        // Drop valid, let every result come back, then watch a little longer
        // for anything spurious.
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
